### sv/etb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etb_pkg
// Shared types and codes for the elapsed timer bank: request and response
// beats, operation modes and the stamp memory command.
// ----------------------------------------------------------------------------
package etb_pkg;

   localparam int TICK_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int MODE_W  = 3;
   localparam int INDEX_W = 3;

   // Operation codes carried in the mode field.
   localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SYNC    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RESTART = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CHECK   = 3'd4;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [INDEX_W-1:0] timer_index;
      logic [TICK_W-1:0]  limit;
   } req_payload_type;

   typedef struct packed {
      logic [TICK_W-1:0] elapsed;
      logic              expired;
   } rsp_payload_type;

   // One access to the stamp memory.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } stamp_cmd_type;

endpackage

### sv/etb_stamp_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etb_stamp_mem
// Start stamp storage: a single-port synchronous memory with a registered
// read. Per-entry valid bits make entries read as zero until written.
// ----------------------------------------------------------------------------
module etb_stamp_mem #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  etb_pkg::stamp_cmd_type        cmd,
   input  logic [AW-1:0]                 addr,
   input  logic [etb_pkg::TICK_W-1:0]    wr_data,
   output logic [etb_pkg::TICK_W-1:0]    rd_data
);

   logic [etb_pkg::TICK_W-1:0] mem [DEPTH];
   logic [etb_pkg::TICK_W-1:0] rd_raw_ff;
   logic                       rd_valid_ff;
   logic [DEPTH-1:0]           valid_ff;

   // Array write and registered read.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_raw_ff   <= mem[addr];
         rd_valid_ff <= valid_ff[addr];
      end
   end

   // Valid bits stand in for clearing the array at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   // An entry that was never written reads as zero.
   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule

### sv/elapsed_timer_bank_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elapsed_timer_bank_unit
// Bank of elapsed-time timers that share one 16-bit tick counter.
// ----------------------------------------------------------------------------
// Tick, sync and restart beats produce no response. Read and check beats
// fetch the start stamp from the single-port stamp memory in the accept
// cycle and enter the access state, where the elapsed value is formed,
// compared and, on expiry, written back once the output register is free;
// no new beat is accepted while a read or check is in the access state. A
// finished response sits in an output register, and new beats are accepted
// while it waits; only a second read or check stalls until the first is taken.
// Stamps read as zero after reset without any clearing pass.
module elapsed_timer_bank_unit #(
   parameter int TIMER_COUNT = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  etb_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output etb_pkg::rsp_payload_type rsp_data
);

   localparam int AW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_ACCESS = 1'b1;

   logic                       state_ff, state_in;
   logic [etb_pkg::TICK_W-1:0] live_ff, live_in;
   logic [etb_pkg::TICK_W-1:0] visible_ff, visible_in;
   logic [etb_pkg::BYTE_W-1:0] last_low_ff, last_low_in;

   // Held request for the access cycle.
   logic [AW-1:0]              addr_ff;
   logic                       in_range_ff;
   logic                       is_check_ff;
   logic [etb_pkg::TICK_W-1:0] limit_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   etb_pkg::rsp_payload_type   rsp_data_ff;

   logic                       accept;
   logic                       req_in_range;
   logic                       rsp_free;
   logic                       finish;
   logic [etb_pkg::TICK_W-1:0] stamp_rd;
   logic [etb_pkg::TICK_W-1:0] stamp;
   logic [etb_pkg::TICK_W-1:0] elapsed;
   logic                       expired;
   etb_pkg::stamp_cmd_type     cmd;
   logic [AW-1:0]              mem_addr;

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign req_in_range = (32'(req_data.timer_index) < TIMER_COUNT);
   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign finish       = (state_ff == ST_ACCESS) && rsp_free;

   // Elapsed value and expiry for the held request.
   assign stamp   = in_range_ff ? stamp_rd : '0;
   assign elapsed = visible_ff - stamp;
   assign expired = is_check_ff && (elapsed > limit_ff);

   // Stamp memory access: fetch or restart on accept, write back on expiry.
   always_comb begin
      cmd.rd_en = 1'b0;
      cmd.wr_en = 1'b0;
      mem_addr  = addr_ff;
      if (accept) begin
         mem_addr = AW'(req_data.timer_index);
         unique case (req_data.mode)
            etb_pkg::MODE_RESTART: cmd.wr_en = req_in_range;
            etb_pkg::MODE_READ, etb_pkg::MODE_CHECK: cmd.rd_en = 1'b1;
            default: ;
         endcase
      end else if (finish) begin
         cmd.wr_en = expired && in_range_ff;
      end
   end

   etb_stamp_mem #(
      .DEPTH (TIMER_COUNT),
      .AW    (AW)
   ) u_stamp_mem (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .addr    (mem_addr),
      .wr_data (visible_ff),
      .rd_data (stamp_rd)
   );

   // Counters and control next state.
   always_comb begin
      state_in     = state_ff;
      live_in      = live_ff;
      visible_in   = visible_ff;
      last_low_in  = last_low_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         unique case (req_data.mode)
            etb_pkg::MODE_TICK: live_in = live_ff + 16'd1;
            etb_pkg::MODE_SYNC: begin
               if (live_ff[etb_pkg::BYTE_W-1:0] != last_low_ff) begin
                  last_low_in = live_ff[etb_pkg::BYTE_W-1:0];
                  visible_in  = live_ff;
               end
            end
            etb_pkg::MODE_READ, etb_pkg::MODE_CHECK: state_in = ST_ACCESS;
            default: ;
         endcase
      end
      if (finish) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         visible_ff   <= '0;
         last_low_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         visible_ff   <= visible_in;
         last_low_ff  <= last_low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request fields held for the access cycle, and the response beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff     <= AW'(req_data.timer_index);
         in_range_ff <= req_in_range;
         is_check_ff <= (req_data.mode == etb_pkg::MODE_CHECK);
         limit_ff    <= req_data.limit;
      end
      if (finish) begin
         rsp_data_ff.elapsed <= elapsed;
         rsp_data_ff.expired <= expired;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A read or check always moves on to the access cycle.
   a_access_follows: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.mode == etb_pkg::MODE_READ ||
                 req_data.mode == etb_pkg::MODE_CHECK) |=> state_ff == ST_ACCESS)
      else $error("read or check did not enter the access cycle");

   // A response appears only at the end of an access cycle.
   a_rsp_from_access: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_ACCESS))
      else $error("response raised outside an access cycle");

   // Stamp writes target only timers that exist.
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> ((accept && req_in_range) || (!accept && in_range_ff)))
      else $error("stamp write to a timer beyond the bank");

   // A tick advances the live counter by exactly one.
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.mode == etb_pkg::MODE_TICK |=>
         live_ff == 16'($past(live_ff) + 16'd1))
      else $error("tick did not advance the live counter");

   // A read never reports expiry.
   a_read_not_expired: assert property (@(posedge clock) disable iff (reset)
      finish && !is_check_ff |=> !rsp_data_ff.expired)
      else $error("read response flagged as expired");

endmodule
